### hdl/mrfc_pkg.sv
// ----------------------------------------------------------------------------
// mrfc_pkg
// Types and constants shared by the rounding feasibility check block.
// ----------------------------------------------------------------------------
package mrfc_pkg;

  typedef logic signed [31:0] q16_t;
  typedef logic signed [63:0] q32_t;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ROW    = 2'd1,
    OP_FINISH = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [0:0] {
    REG_OFFSET    = 1'b0,
    REG_TOLERANCE = 1'b1
  } reg_index_t;

  localparam q16_t Q_NEG_INF  = 32'sh8000_0000;
  localparam q16_t Q_POS_INF  = 32'sh7FFF_FFFF;
  // value given to an integer column that rounds past the top of the range
  localparam q16_t ROUND_SAT  = 32'sh7FFF_0000;
  localparam q32_t SUM_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam q32_t SUM_MIN    = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [9:0]  column_index;
    q16_t        value;
    q16_t        lower_bound;
    q16_t        upper_bound;
    q16_t        objective_coefficient;
    logic        is_integer;
    logic        row_end;
  } item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    q16_t        rounded_value;
    logic        rows_violated;
    q32_t        objective;
    logic        accepted;
  } result_t;

endpackage

### hdl/mip_rounding_feasibility_check.sv
// ----------------------------------------------------------------------------
// mip_rounding_feasibility_check
// Rounds and stores column values, accumulates row and objective sums and
// checks rows and the objective of a rounded solution.
// ----------------------------------------------------------------------------
//  channel  | signals                        | direction | payload
//  ---------+--------------------------------+-----------+-------------------
//  item     | item_valid, item_stall, item   | in        | mrfc_pkg::item_t
//  result   | result_valid, result_stall,    | out       | mrfc_pkg::result_t
//           | result                         |           |
//  config   | cfg_we, cfg_index, cfg_data    | in        | 32 bit write data
//
//  one request at a time through a sequencer around one shared multiplier,
//  one saturating 64 bit adder and one 64 bit compare
//  load steps: round, multiply, accumulate, done; row entry steps: multiply,
//  accumulate, lower and upper check at row end, done; finish steps:
//  accumulate, final check, done; a stalled result holds the sequencer in its last step
//  reset clears control, sums, flag and offset and sets tolerance to 1; the column store is not
//  cleared, a column must be loaded before a row entry reads it
// ----------------------------------------------------------------------------
module mip_rounding_feasibility_check #(
  parameter int MAX_COLUMNS = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  mrfc_pkg::item_t     item,
  output logic                result_valid,
  input  logic                result_stall,
  output mrfc_pkg::result_t   result,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_RND     = 8'b0000_0010,
    S_MUL     = 8'b0000_0100,
    S_ACC     = 8'b0000_1000,
    S_CHK_LO  = 8'b0001_0000,
    S_CHK_HI  = 8'b0010_0000,
    S_FIN_CHK = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  function automatic mrfc_pkg::q32_t sat_add(input mrfc_pkg::q32_t a, input mrfc_pkg::q32_t b);
    mrfc_pkg::q32_t s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) begin
      return a[63] ? mrfc_pkg::SUM_MIN : mrfc_pkg::SUM_MAX;
    end
    return s;
  endfunction

  state_t            state;
  state_t            state_next;
  mrfc_pkg::item_t   req;
  logic              in_range;
  mrfc_pkg::q16_t    rnd;
  mrfc_pkg::q32_t    prod;
  mrfc_pkg::q32_t    row_sum;
  mrfc_pkg::q32_t    objective_sum;
  mrfc_pkg::q32_t    obj;
  logic              violation_flag;
  logic              acc_bit;
  mrfc_pkg::q16_t    objective_offset;
  logic [15:0]       tolerance;

  logic              accept;
  logic              out_load;
  logic [16:0]       col_wide;
  logic [16:0]       req_col_wide;
  logic [AW-1:0]     raddr;
  logic [AW-1:0]     waddr;
  logic [31:0]       ram_rdata;
  mrfc_pkg::q16_t    round_out;
  mrfc_pkg::q16_t    mul_a;
  mrfc_pkg::q16_t    mul_b;
  mrfc_pkg::q32_t    mul_p;
  mrfc_pkg::q32_t    add_a;
  mrfc_pkg::q32_t    add_b;
  mrfc_pkg::q32_t    add_s;
  mrfc_pkg::q16_t    thr_bound;
  logic              thr_sub;
  logic signed [33:0] thr_base;
  mrfc_pkg::q32_t    thr;
  mrfc_pkg::q32_t    cmp_a;
  mrfc_pkg::q32_t    cmp_b;
  logic              cmp_lt;

  assign item_stall   = (state != S_IDLE);
  assign accept       = item_valid && !item_stall;
  assign out_load     = (state == S_DONE) && (!result_valid || !result_stall);
  assign col_wide     = {7'b0, item.column_index};
  assign req_col_wide = {7'b0, req.column_index};
  assign raddr        = col_wide[AW-1:0];
  assign waddr        = req_col_wide[AW-1:0];

  mrfc_ram #(
    .WIDTH (32),
    .DEPTH (MAX_COLUMNS)
  ) u_store (
    .clk   (clk),
    .we    ((state == S_RND) && in_range),
    .waddr (waddr),
    .wdata (round_out),
    .re    (accept && item.opcode == mrfc_pkg::OP_ROW),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  mrfc_round u_round (
    .value       (req.value),
    .lower_bound (req.lower_bound),
    .upper_bound (req.upper_bound),
    .is_integer  (req.is_integer),
    .rounded     (round_out)
  );

  // shared multiplier: objective term on load, coefficient times value on a row
  always_comb begin
    if (req.opcode == mrfc_pkg::OP_LOAD) begin
      mul_a = req.objective_coefficient;
      mul_b = rnd;
    end else begin
      mul_a = req.value;
      mul_b = in_range ? ram_rdata : '0;
    end
    mul_p = mul_a * mul_b;
  end

  // shared saturating adder
  always_comb begin
    unique case (req.opcode)
      mrfc_pkg::OP_LOAD: begin
        add_a = objective_sum;
        add_b = prod;
      end
      mrfc_pkg::OP_ROW: begin
        add_a = row_sum;
        add_b = prod;
      end
      default: begin
        add_a = objective_sum;
        add_b = {{16{objective_offset[31]}}, objective_offset, 16'b0};
      end
    endcase
    add_s = sat_add(add_a, add_b);
  end

  // shared threshold and compare: (bound -/+ tol) scaled to Q32.32
  always_comb begin
    thr_bound = req.value;
    thr_sub   = 1'b1;
    cmp_a     = obj;
    cmp_b     = '0;
    unique case (state)
      S_CHK_LO: begin
        thr_bound = req.lower_bound;
        thr_sub   = 1'b1;
      end
      S_CHK_HI: begin
        thr_bound = req.upper_bound;
        thr_sub   = 1'b0;
      end
      default: begin
        thr_bound = req.value;
        thr_sub   = 1'b1;
      end
    endcase
    if (thr_sub) begin
      thr_base = {{2{thr_bound[31]}}, thr_bound} - {18'b0, tolerance};
    end else begin
      thr_base = {{2{thr_bound[31]}}, thr_bound} + {18'b0, tolerance};
    end
    thr = {{14{thr_base[33]}}, thr_base, 16'b0};
    unique case (state)
      S_CHK_LO: begin
        cmp_a = row_sum;
        cmp_b = thr;
      end
      S_CHK_HI: begin
        cmp_a = thr;
        cmp_b = row_sum;
      end
      default: begin
        cmp_a = obj;
        cmp_b = thr;
      end
    endcase
    cmp_lt = cmp_a < cmp_b;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (item.opcode)
            mrfc_pkg::OP_LOAD:   state_next = S_RND;
            mrfc_pkg::OP_ROW:    state_next = S_MUL;
            mrfc_pkg::OP_FINISH: state_next = S_ACC;
            default:             state_next = S_IDLE;
          endcase
        end
      end
      S_RND:     state_next = S_MUL;
      S_MUL:     state_next = S_ACC;
      S_ACC: begin
        if (req.opcode == mrfc_pkg::OP_FINISH) begin
          state_next = S_FIN_CHK;
        end else if (req.opcode == mrfc_pkg::OP_ROW && req.row_end) begin
          state_next = S_CHK_LO;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CHK_LO:  state_next = S_CHK_HI;
      S_CHK_HI:  state_next = S_DONE;
      S_FIN_CHK: state_next = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      row_sum        <= '0;
      objective_sum  <= '0;
      violation_flag <= 1'b0;
      result_valid   <= 1'b0;
      objective_offset <= '0;
      tolerance      <= 16'd1;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          mrfc_pkg::REG_OFFSET:    objective_offset <= cfg_data;
          mrfc_pkg::REG_TOLERANCE: tolerance        <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (state == S_ACC) begin
        if (req.opcode == mrfc_pkg::OP_LOAD) begin
          objective_sum <= add_s;
        end else if (req.opcode == mrfc_pkg::OP_ROW) begin
          row_sum <= add_s;
        end
      end
      if (state == S_CHK_LO && req.lower_bound != mrfc_pkg::Q_NEG_INF && cmp_lt) begin
        violation_flag <= 1'b1;
      end
      if (state == S_CHK_HI) begin
        if (req.upper_bound != mrfc_pkg::Q_POS_INF && cmp_lt) begin
          violation_flag <= 1'b1;
        end
        row_sum <= '0;
      end
      if (out_load) begin
        result_valid <= 1'b1;
        if (req.opcode == mrfc_pkg::OP_FINISH) begin
          row_sum        <= '0;
          objective_sum  <= '0;
          violation_flag <= 1'b0;
        end
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req      <= item;
      in_range <= col_wide < 17'(MAX_COLUMNS);
    end
    if (state == S_RND) begin
      rnd <= round_out;
    end
    if (state == S_MUL) begin
      prod <= mul_p;
    end
    if (state == S_ACC) begin
      obj <= add_s;
    end
    if (state == S_FIN_CHK) begin
      acc_bit <= !violation_flag && (req.value == mrfc_pkg::Q_POS_INF || cmp_lt);
    end
    if (out_load) begin
      result.result_kind   <= req.opcode;
      result.rounded_value <= (req.opcode == mrfc_pkg::OP_LOAD) ? rnd : '0;
      result.rows_violated <= violation_flag;
      result.objective     <= (req.opcode == mrfc_pkg::OP_FINISH) ? obj : '0;
      result.accepted      <= (req.opcode == mrfc_pkg::OP_FINISH) ? acc_bit : 1'b0;
    end
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    !item_stall |-> state == S_IDLE)
    else $error("request taken while sequencer busy");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_DONE))
    else $error("result raised outside the final step");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    (out_load && req.opcode == mrfc_pkg::OP_FINISH)
      |=> (!violation_flag && objective_sum == '0 && row_sum == '0))
    else $error("finish did not clear sums and flag");

  a_row_sum_cleared: assert property (@(posedge clk) disable iff (rst)
    state == S_CHK_HI |=> row_sum == '0)
    else $error("row sum kept after row end");

  a_accept_on_finish: assert property (@(posedge clk) disable iff (rst)
    (out_load && req.opcode != mrfc_pkg::OP_FINISH) |=> !result.accepted)
    else $error("accepted flag on a non-finish result");

endmodule

### hdl/mrfc_ram.sv
// ----------------------------------------------------------------------------
// mrfc_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mrfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/mrfc_round.sv
// ----------------------------------------------------------------------------
// mrfc_round
// If is_integer, round half away from zero to an integer Q16.16 value and clamp to bounds.
// ----------------------------------------------------------------------------
module mrfc_round (
  input  mrfc_pkg::q16_t value,
  input  mrfc_pkg::q16_t lower_bound,
  input  mrfc_pkg::q16_t upper_bound,
  input  logic           is_integer,
  output mrfc_pkg::q16_t rounded
);

  localparam logic signed [33:0] HALF  = 34'sd32768;
  localparam logic signed [33:0] R_MAX = 34'sh0_7FFF_FFFF;

  logic signed [33:0] v34;
  logic signed [33:0] lo34;
  logic signed [33:0] hi34;
  logic signed [33:0] s;
  logic signed [33:0] n;
  logic signed [33:0] r;

  always_comb begin
    v34  = {{2{value[31]}}, value};
    lo34 = {{2{lower_bound[31]}}, lower_bound};
    hi34 = {{2{upper_bound[31]}}, upper_bound};
    s    = '0;
    n    = '0;
    if (!value[31]) begin
      s = v34 + HALF;
      r = {s[33:16], 16'b0};
      if (r > R_MAX) begin
        r = {2'b00, mrfc_pkg::ROUND_SAT};
      end
    end else begin
      n = -v34;
      s = n + HALF;
      r = -{s[33:16], 16'b0};
    end
    // lower clamp first, so crossed bounds end on the upper one
    if (r < lo34) begin
      r = lo34;
    end
    if (r > hi34) begin
      r = hi34;
    end
    rounded = is_integer ? r[31:0] : value;
  end

endmodule
